// ----- src/srp_pkg.sv -----
// ----------------------------------------------------------------------------
// srp_pkg
// shared types, constants and a time helper of the stage residency profiler
// ----------------------------------------------------------------------------
package srp_pkg;

    localparam int SRP_WINDOW_DEPTH = 16;
    localparam int SRP_NUM_STAGES   = 8;

    localparam int TIME_W     = 32;
    localparam int ACTION_W   = 2;
    localparam int STAGE_IN_W = 4;
    localparam int DOM_W      = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CHANGE = 2'd0,
        ACT_RECORD = 2'd1,
        ACT_QUERY  = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CUR,
        S_RD,
        S_DRAIN,
        S_SCAN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic clear;
        logic feed_vld;
        logic scan_start;
    } t_acc_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_acc_stat;

    // a before b on a wrapping time line
    function automatic logic is_before(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] diff;
        diff = a - b;
        return diff[TIME_W-1];
    endfunction

endpackage

// ----- src/srp_if.sv -----
// ----------------------------------------------------------------------------
// srp_if
// request and result channels of the stage residency profiler
// ----------------------------------------------------------------------------
interface srp_in_if;
    import srp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ACTION_W-1:0]   action;
    logic [STAGE_IN_W-1:0] stage;
    logic [TIME_W-1:0]     from_ms;
    logic [TIME_W-1:0]     to_ms;

    modport source(output valid, action, stage, from_ms, to_ms, input ready);
    modport sink(input valid, action, stage, from_ms, to_ms, output ready);
endinterface

interface srp_out_if;
    import srp_pkg::*;

    logic              valid;
    logic              ready;
    logic [DOM_W-1:0]  dominant_stage;
    logic [TIME_W-1:0] dominant_overlap_ms;

    modport source(output valid, dominant_stage, dominant_overlap_ms, input ready);
    modport sink(input valid, dominant_stage, dominant_overlap_ms, output ready);
endinterface

// ----- src/stage_residency_profiler.sv -----
// ----------------------------------------------------------------------------
// stage_residency_profiler
// change and record requests leave the block idle; a query's duration is set
// by the ring walk over the single memory read port and the one-sum-per-cycle
// stage scan; an empty interval skips the walk and the scan; one request at a
// time, a result may wait while the next request is taken; synchronous reset,
// ring contents need no clearing
// ----------------------------------------------------------------------------
module stage_residency_profiler #(
    parameter int WINDOW_DEPTH = srp_pkg::SRP_WINDOW_DEPTH,
    parameter int NUM_STAGES   = srp_pkg::SRP_NUM_STAGES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    srp_in_if.sink    i_in,
    srp_out_if.source o_out
);
    import srp_pkg::*;

    localparam int IW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int PW = CW + 1;
    localparam int SW = $clog2(NUM_STAGES);
    localparam int DW = SW + 2 * TIME_W;

    t_state            r_state;
    t_state            n_state;
    logic [IW-1:0]     r_wr_idx;
    logic [CW-1:0]     r_count;
    logic [SW-1:0]     r_cur_stg;
    logic [TIME_W-1:0] r_cur_start;
    logic              r_cur_vld;
    logic [TIME_W-1:0] r_from;
    logic [TIME_W-1:0] r_to;
    logic [IW-1:0]     r_rd_ptr;
    logic [CW-1:0]     r_rd_cnt;
    logic              r_rd_vld;
    logic              r_zero;
    logic              r_out_vld;
    logic [DOM_W-1:0]  r_out_stg;
    logic [TIME_W-1:0] r_out_ov;

    logic                  in_acc;
    logic [STAGE_IN_W:0]   stage_ext;
    logic                  in_range;
    logic [SW-1:0]         chg_stg;
    logic [PW-1:0]         first_raw;
    logic [IW-1:0]         first_idx;
    logic                  wr_en;
    logic [SW-1:0]         wr_stg;
    logic [TIME_W-1:0]     wr_start;
    logic [TIME_W-1:0]     wr_end;
    logic                  open_en;
    logic                  query_go;
    logic                  rd_issue;
    logic                  out_load;
    t_acc_ctrl             acc_ctrl;
    t_acc_stat             acc_stat;
    logic [DW-1:0]         rd_data;
    logic [SW-1:0]         feed_stg;
    logic [TIME_W-1:0]     feed_start;
    logic [TIME_W-1:0]     feed_end;
    logic [SW-1:0]         best_stg;
    logic [TIME_W-1:0]     best;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;

    assign stage_ext = {1'b0, i_in.stage};
    assign in_range  = stage_ext < (STAGE_IN_W + 1)'(NUM_STAGES);
    assign chg_stg   = in_range ? SW'(i_in.stage) : SW'(NUM_STAGES - 1);

    // oldest stored window
    assign first_raw = PW'(r_wr_idx) + PW'(WINDOW_DEPTH) - PW'(r_count);
    assign first_idx = (first_raw >= PW'(WINDOW_DEPTH)) ?
                       IW'(first_raw - PW'(WINDOW_DEPTH)) : IW'(first_raw);

    always_comb begin
        wr_en    = 1'b0;
        wr_stg   = r_cur_stg;
        wr_start = r_cur_start;
        wr_end   = i_in.from_ms;
        open_en  = 1'b0;
        query_go = 1'b0;
        if (in_acc) begin
            unique case (i_in.action)
                ACT_CHANGE: begin
                    if (!r_cur_vld) begin
                        open_en = 1'b1;
                    end else if (chg_stg != r_cur_stg) begin
                        open_en = 1'b1;
                        wr_en   = is_before(r_cur_start, i_in.from_ms);
                    end
                end
                ACT_RECORD: begin
                    wr_stg   = SW'(i_in.stage);
                    wr_start = i_in.from_ms;
                    wr_end   = i_in.to_ms;
                    wr_en    = in_range && is_before(i_in.from_ms, i_in.to_ms);
                end
                ACT_QUERY: begin
                    query_go = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx  <= '0;
            r_count   <= '0;
            r_cur_vld <= 1'b0;
        end else begin
            if (wr_en) begin
                r_wr_idx <= (r_wr_idx == IW'(WINDOW_DEPTH - 1)) ? '0 : r_wr_idx + IW'(1);
                if (r_count != CW'(WINDOW_DEPTH)) begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (open_en) begin
                r_cur_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (open_en) begin
            r_cur_stg   <= chg_stg;
            r_cur_start <= i_in.from_ms;
        end
        if (query_go) begin
            r_from <= i_in.from_ms;
            r_to   <= i_in.to_ms;
            r_zero <= !is_before(i_in.from_ms, i_in.to_ms);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        acc_ctrl = '0;
        rd_issue = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (query_go) begin
                    acc_ctrl.clear = 1'b1;
                    n_state = is_before(i_in.from_ms, i_in.to_ms) ? S_CUR : S_OUT;
                end
            end
            S_CUR: begin
                acc_ctrl.feed_vld = r_cur_vld;
                n_state = S_RD;
            end
            S_RD: begin
                if (r_rd_cnt == r_count) begin
                    n_state = S_DRAIN;
                end else begin
                    rd_issue = 1'b1;
                end
            end
            S_DRAIN: begin
                if (!r_rd_vld && !acc_stat.busy) begin
                    acc_ctrl.scan_start = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (acc_stat.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_vld || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        acc_ctrl.feed_vld = acc_ctrl.feed_vld | r_rd_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= rd_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (query_go) begin
            r_rd_ptr <= first_idx;
            r_rd_cnt <= '0;
        end else if (rd_issue) begin
            r_rd_ptr <= (r_rd_ptr == IW'(WINDOW_DEPTH - 1)) ? '0 : r_rd_ptr + IW'(1);
            r_rd_cnt <= r_rd_cnt + CW'(1);
        end
    end

    srp_ring_mem #(
        .DEPTH (WINDOW_DEPTH),
        .DW    (DW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_wr_idx),
        .i_wdata ({wr_stg, wr_start, wr_end}),
        .i_re    (rd_issue),
        .i_raddr (r_rd_ptr),
        .o_rdata (rd_data)
    );

    // open stage runs up to the query end
    always_comb begin
        if (r_state == S_CUR) begin
            feed_stg   = r_cur_stg;
            feed_start = r_cur_start;
            feed_end   = r_to;
        end else begin
            feed_stg   = rd_data[DW-1 -: SW];
            feed_start = rd_data[2*TIME_W-1 -: TIME_W];
            feed_end   = rd_data[TIME_W-1:0];
        end
    end

    srp_stage_acc #(
        .NUM_STAGES (NUM_STAGES)
    ) u_acc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (acc_ctrl),
        .i_from     (r_from),
        .i_to       (r_to),
        .i_stg      (feed_stg),
        .i_start    (feed_start),
        .i_end      (feed_end),
        .o_stat     (acc_stat),
        .o_best_stg (best_stg),
        .o_best     (best)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_stg <= r_zero ? '0 : DOM_W'(best_stg);
            r_out_ov  <= r_zero ? '0 : best;
        end
    end

    assign o_out.valid               = r_out_vld;
    assign o_out.dominant_stage      = r_out_stg;
    assign o_out.dominant_overlap_ms = r_out_ov;
endmodule

// ----- src/srp_ring_mem.sv -----
// ----------------------------------------------------------------------------
// srp_ring_mem
// window ring storage, one write and one registered read port
// ----------------------------------------------------------------------------
module srp_ring_mem #(
    parameter int DEPTH = srp_pkg::SRP_WINDOW_DEPTH,
    parameter int DW    = 67
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/srp_stage_acc.sv -----
// ----------------------------------------------------------------------------
// srp_stage_acc
// overlap pipeline, per stage sums and the dominant stage scan
// ----------------------------------------------------------------------------
module srp_stage_acc #(
    parameter int NUM_STAGES = srp_pkg::SRP_NUM_STAGES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  srp_pkg::t_acc_ctrl            i_ctrl,
    input  logic [srp_pkg::TIME_W-1:0]    i_from,
    input  logic [srp_pkg::TIME_W-1:0]    i_to,
    input  logic [$clog2(NUM_STAGES)-1:0] i_stg,
    input  logic [srp_pkg::TIME_W-1:0]    i_start,
    input  logic [srp_pkg::TIME_W-1:0]    i_end,
    output srp_pkg::t_acc_stat            o_stat,
    output logic [$clog2(NUM_STAGES)-1:0] o_best_stg,
    output logic [srp_pkg::TIME_W-1:0]    o_best
);
    import srp_pkg::*;

    localparam int SW = $clog2(NUM_STAGES);

    logic              r_s1_vld;
    logic [SW-1:0]     r_s1_stg;
    logic [TIME_W-1:0] r_s1_s;
    logic [TIME_W-1:0] r_s1_e;
    logic              r_s2_vld;
    logic [SW-1:0]     r_s2_stg;
    logic [TIME_W-1:0] r_s2_ov;
    logic [TIME_W-1:0] r_sums [NUM_STAGES];
    logic              r_scan_act;
    logic [SW-1:0]     r_scan_idx;
    logic              r_done;
    logic [SW-1:0]     r_best_stg;
    logic [TIME_W-1:0] r_best;
    logic [SW-1:0]     rd_idx;
    logic [TIME_W-1:0] rd_sum;

    // later start and earlier end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_ctrl.feed_vld;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_stg <= i_stg;
        r_s1_s   <= is_before(i_from, i_start) ? i_start : i_from;
        r_s1_e   <= is_before(i_to, i_end) ? i_to : i_end;
        r_s2_stg <= r_s1_stg;
        r_s2_ov  <= is_before(r_s1_s, r_s1_e) ? (r_s1_e - r_s1_s) : '0;
    end

    assign rd_idx = r_scan_act ? r_scan_idx : r_s2_stg;
    assign rd_sum = r_sums[rd_idx];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                r_sums[k] <= '0;
            end
        end else if (r_s2_vld) begin
            r_sums[r_s2_stg] <= rd_sum + r_s2_ov;
        end
    end

    // scan non-idle stages, earliest wins on ties
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_act <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.scan_start) begin
                r_scan_act <= 1'b1;
            end else if (r_scan_act && r_scan_idx == SW'(NUM_STAGES - 1)) begin
                r_scan_act <= 1'b0;
                r_done     <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.scan_start) begin
            r_scan_idx <= SW'(1);
            r_best_stg <= '0;
            r_best     <= '0;
        end else if (r_scan_act) begin
            r_scan_idx <= r_scan_idx + SW'(1);
            if (rd_sum > r_best) begin
                r_best     <= rd_sum;
                r_best_stg <= r_scan_idx;
            end
        end
    end

    assign o_stat.busy = r_s1_vld | r_s2_vld;
    assign o_stat.done = r_done;
    assign o_best_stg  = r_best_stg;
    assign o_best      = r_best;
endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the stage residency profiler: directed requests
// cover an empty profile, stage changes, rejected windows, wrapping times and
// sums, then random traffic runs under three sender and receiver stall mixes
// and a long result hold-off; every query result is compared field by field
// against a built-in model of the window ring and the open stage
// ----------------------------------------------------------------------------
module tb;
    import srp_pkg::*;

    localparam int          WIN_DEPTH     = SRP_WINDOW_DEPTH;
    localparam int          NUM_ST        = SRP_NUM_STAGES;
    localparam int          STAGE_IDLE    = 0;
    localparam int          STAGE_OTHER   = NUM_ST - 1;
    localparam int          STAGE_NONE    = NUM_ST;
    localparam logic [1:0]  ACT_UNUSED    = 2'd3;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          MAX_REPORTS   = 10;

    typedef struct packed {
        logic [DOM_W-1:0]  stg;
        logic [TIME_W-1:0] ovl;
    } t_residency;

    logic i_clk;
    logic i_rst_n;

    srp_in_if  req_if ();
    srp_out_if res_if ();

    stage_residency_profiler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    // model of the window ring and the open stage
    logic [DOM_W-1:0]  ring_stage [WIN_DEPTH];
    logic [TIME_W-1:0] ring_start [WIN_DEPTH];
    logic [TIME_W-1:0] ring_end   [WIN_DEPTH];
    int unsigned       ring_wr;
    int unsigned       ring_cnt;
    logic [DOM_W-1:0]  open_stage;
    logic [TIME_W-1:0] open_start;
    bit                open_valid;

    t_residency  expected_dominance [$];
    int          mismatch_cnt;
    int          cycle_cnt;
    int          src_idle_pct;
    int          snk_idle_pct;
    int          hold_left;
    logic [31:0] now_ms;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit earlier(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    function automatic logic [31:0] shared_ms(input logic [31:0] s1, input logic [31:0] e1,
                                              input logic [31:0] s2, input logic [31:0] e2);
        logic [31:0] s;
        logic [31:0] e;
        s = earlier(s1, s2) ? s2 : s1;
        e = earlier(e1, e2) ? e1 : e2;
        if (!earlier(s, e))
            return 32'd0;
        return e - s;
    endfunction

    function automatic void log_window(input int unsigned stg, input logic [31:0] s,
                                       input logic [31:0] e);
        if (stg >= NUM_ST || !earlier(s, e))
            return;
        ring_stage[ring_wr] = stg[DOM_W-1:0];
        ring_start[ring_wr] = s;
        ring_end[ring_wr]   = e;
        ring_wr = (ring_wr + 1) % WIN_DEPTH;
        if (ring_cnt < WIN_DEPTH)
            ring_cnt++;
    endfunction

    function automatic t_residency dominant_in(input logic [31:0] f, input logic [31:0] t);
        logic [31:0] sums [NUM_ST];
        t_residency  r;
        int unsigned first;
        int unsigned idx;
        r.stg = DOM_W'(STAGE_IDLE);
        r.ovl = 32'd0;
        if (!earlier(f, t))
            return r;
        for (int k = 0; k < NUM_ST; k++)
            sums[k] = 32'd0;
        first = (ring_wr + WIN_DEPTH - ring_cnt) % WIN_DEPTH;
        for (int k = 0; k < ring_cnt; k++) begin
            idx = (first + k) % WIN_DEPTH;
            sums[ring_stage[idx]] += shared_ms(f, t, ring_start[idx], ring_end[idx]);
        end
        if (open_valid)
            sums[open_stage] += shared_ms(f, t, open_start, t);
        for (int k = 1; k < NUM_ST; k++) begin
            if (sums[k] > r.ovl) begin
                r.ovl = sums[k];
                r.stg = DOM_W'(k);
            end
        end
        return r;
    endfunction

    function automatic void apply_request(input logic [1:0] act, input logic [3:0] stg,
                                          input logic [31:0] f, input logic [31:0] t);
        int unsigned mapped;
        mapped = (stg >= NUM_ST) ? STAGE_OTHER : stg;
        case (act)
            ACT_CHANGE: begin
                if (!open_valid) begin
                    open_stage = DOM_W'(mapped);
                    open_start = f;
                    open_valid = 1'b1;
                end else if (open_stage != mapped) begin
                    log_window(open_stage, open_start, f);
                    open_stage = DOM_W'(mapped);
                    open_start = f;
                end
            end
            ACT_RECORD: log_window(stg, f, t);
            ACT_QUERY:  expected_dominance.push_back(dominant_in(f, t));
            default: ;
        endcase
    endfunction

    function automatic void report_mismatch(input string what, input logic [31:0] want,
                                            input logic [31:0] got);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
            $display("tb mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
    endfunction

    task automatic send_request(input logic [1:0] act, input logic [3:0] stg,
                                input logic [31:0] f, input logic [31:0] t);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid   = 1'b1;
        req_if.action  = act;
        req_if.stage   = stg;
        req_if.from_ms = f;
        req_if.to_ms   = t;
        do @(posedge i_clk); while (!req_if.ready);
        apply_request(act, stg, f, t);
        @(negedge i_clk);
        req_if.valid = 1'b0;
    endtask

    // result receiver, with an optional long hold-off
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                res_if.ready = 1'b0;
                hold_left--;
            end else begin
                res_if.ready = ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_residency want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_dominance.size() == 0) begin
                report_mismatch("result with no query pending", 32'd0,
                                res_if.dominant_overlap_ms);
            end else begin
                want = expected_dominance.pop_front();
                if (res_if.dominant_stage !== want.stg)
                    report_mismatch("dominant_stage", 32'(want.stg),
                                    32'(res_if.dominant_stage));
                if (res_if.dominant_overlap_ms !== want.ovl)
                    report_mismatch("dominant_overlap_ms", want.ovl,
                                    res_if.dominant_overlap_ms);
            end
        end
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("tb: failure");
        $finish;
    end

    task automatic test_empty_profile();
        send_request(ACT_QUERY, 4'd0, 32'd100, 32'd200);
        send_request(ACT_QUERY, 4'hF, 32'd0, 32'hFFFF_FFFF);
    endtask

    task automatic test_stage_changes();
        // first change only opens, repeat is ignored, none maps to other
        send_request(ACT_CHANGE, 4'd3, 32'd1000, 32'hFFFF_FFFF);
        send_request(ACT_QUERY, 4'd0, 32'd500, 32'd1500);
        send_request(ACT_CHANGE, 4'd3, 32'd1200, 32'd0);
        send_request(ACT_CHANGE, 4'(STAGE_NONE), 32'd2000, 32'd0);
        send_request(ACT_QUERY, 4'd0, 32'd0, 32'd3000);
    endtask

    task automatic test_record_rules();
        send_request(ACT_RECORD, 4'(STAGE_NONE), 32'd10, 32'd20);
        send_request(ACT_RECORD, 4'hF, 32'd10, 32'd20);
        send_request(ACT_RECORD, 4'd4, 32'd50, 32'd50);
        send_request(ACT_RECORD, 4'd4, 32'd90, 32'd60);
        send_request(ACT_RECORD, 4'(STAGE_IDLE), 32'd0, 32'd5000);
        send_request(ACT_RECORD, 4'd5, 32'hFFFF_FF00, 32'h0000_0100);
        send_request(ACT_QUERY, 4'd0, 32'hFFFF_FF80, 32'h0000_0080);
    endtask

    task automatic test_overlap_wrap();
        // three long windows of one stage wrap its sum
        repeat (3) send_request(ACT_RECORD, 4'd2, 32'd0, 32'h7FFF_FFFF);
        send_request(ACT_QUERY, 4'd0, 32'd0, 32'h7FFF_FFFF);
    endtask

    task automatic test_unused_action();
        send_request(ACT_UNUSED, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(ACT_QUERY, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    endtask

    task automatic test_backpressure();
        int keep_pct;
        keep_pct     = src_idle_pct;
        src_idle_pct = 0;
        hold_left    = 300;
        repeat (24)
            send_request(ACT_QUERY, 4'd0, now_ms - $urandom_range(0, 4000),
                         now_ms + $urandom_range(0, 2000));
        src_idle_pct = keep_pct;
    endtask

    task automatic test_random_traffic(input int n_items);
        int          pick;
        logic [3:0]  stg;
        logic [31:0] f;
        logic [31:0] t;
        logic [31:0] swap;
        for (int n = 0; n < n_items; n++) begin
            pick = $urandom_range(99);
            if ($urandom_range(49) == 0)
                now_ms = ($urandom_range(1) != 0) ? 32'hFFFF_F000 + $urandom_range(0, 3000)
                                                  : $urandom;
            if (pick < 8) begin
                send_request(2'($urandom_range(3)), 4'($urandom_range(15)), $urandom,
                             $urandom);
            end else if (pick < 33) begin
                now_ms += $urandom_range(1, 400);
                stg = ($urandom_range(9) == 0) ? 4'($urandom_range(STAGE_NONE, 15))
                                               : 4'($urandom_range(0, STAGE_OTHER));
                send_request(ACT_CHANGE, stg, now_ms, $urandom);
            end else if (pick < 55) begin
                f = now_ms - $urandom_range(0, 3000);
                t = f + $urandom_range(0, 800);
                if ($urandom_range(9) == 0) begin
                    swap = f;
                    f    = t;
                    t    = swap;
                end
                stg = ($urandom_range(14) == 0) ? 4'($urandom_range(STAGE_NONE, 15))
                                                : 4'($urandom_range(0, STAGE_OTHER));
                send_request(ACT_RECORD, stg, f, t);
            end else begin
                f = now_ms - $urandom_range(0, 5000);
                case ($urandom_range(9))
                    0:       t = f - $urandom_range(0, 100);
                    1:       t = f + $urandom_range(0, 32'h7FFF_FFFF);
                    default: t = f + $urandom_range(1, 6000);
                endcase
                send_request(ACT_QUERY, 4'($urandom_range(15)), f, t);
            end
        end
    endtask

    initial begin
        req_if.valid   = 1'b0;
        req_if.action  = ACT_CHANGE;
        req_if.stage   = '0;
        req_if.from_ms = '0;
        req_if.to_ms   = '0;
        i_rst_n        = 1'b0;
        ring_wr        = 0;
        ring_cnt       = 0;
        open_stage     = DOM_W'(STAGE_IDLE);
        open_start     = '0;
        open_valid     = 1'b0;
        mismatch_cnt   = 0;
        hold_left      = 0;
        src_idle_pct   = 13;
        snk_idle_pct   = 85;
        now_ms         = $urandom;
        for (int k = 0; k < WIN_DEPTH; k++) begin
            ring_stage[k] = '0;
            ring_start[k] = '0;
            ring_end[k]   = '0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_profile();
        test_stage_changes();
        test_record_rules();
        test_overlap_wrap();
        test_unused_action();
        test_random_traffic(165);
        test_backpressure();
        src_idle_pct = 85;
        snk_idle_pct = 13;
        test_random_traffic(165);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_traffic(175);

        while (expected_dominance.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
